// ===== sv/mf3_pkg.sv =====
// types, constants and compare helpers shared by the 3x3 median filter modules
package mf3_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int WIN_SIZE      = 3;
  localparam int WIN_AREA      = WIN_SIZE * WIN_SIZE;
  localparam int WIN_HALF      = WIN_SIZE / 2;
  localparam int PIX_W         = 8;
  localparam int CNT_W         = 11;
  localparam int CFG_W         = 12;
  localparam int CFG_IDX_W     = 1;
  localparam int Q_DEPTH       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 12'd512;
  localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 12'd512;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_AREA-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [CNT_W-1:0] out_row;
    logic [CNT_W-1:0] out_col;
    logic             last_of_frame;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] out_row;
    logic [CNT_W-1:0] out_col;
    logic             last_of_frame;
  } meta_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CNT_W-1:0] col;
    logic [CNT_W-1:0] out_row;
    logic             emit;
    logic             last;
  } entry_t;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] hi;
  } tri_t;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic tri_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t l1;
    pix_t h1;
    pix_t h2;
    tri_t t;
    l1    = min2(a, b);
    h1    = max2(a, b);
    h2    = max2(h1, c);
    t.hi  = h2;
    t.lo  = min2(l1, min2(h1, c));
    t.mid = max2(l1, min2(h1, c));
    return t;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

// ===== sv/mf3_front.sv =====
// front end: configuration registers, raster counters and per-pixel classification
module mf3_front #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]          cfg_data,
  input  logic                               pix_valid,
  input  mf3_pkg::pixel_t                    pix_data,
  input  logic                               q_full,
  output logic                               push,
  output mf3_pkg::entry_t                    entry
);

  localparam int LW = ($clog2(MAX_WIDTH + 1) > mf3_pkg::CFG_W) ?
                      $clog2(MAX_WIDTH + 1) : mf3_pkg::CFG_W;
  localparam int CW = mf3_pkg::CNT_W;
  localparam int HW = mf3_pkg::CFG_W;

  logic [mf3_pkg::CFG_W-1:0] image_width;
  logic [mf3_pkg::CFG_W-1:0] image_height;
  logic [CW-1:0]             row_count;
  logic [CW-1:0]             col_count;
  logic [CW-1:0]             row_count_next;
  logic [CW-1:0]             col_count_next;

  logic [LW-1:0] w_ext;
  logic [LW-1:0] w_last;
  logic [HW-1:0] h_last;
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic          row_end;
  logic          frame_end;

  assign push = pix_valid && !q_full;

  always_comb begin
    w_ext = LW'(image_width);
    if (w_ext < LW'(mf3_pkg::WIN_SIZE)) begin
      w_last = LW'(mf3_pkg::WIN_SIZE - 1);
    end else if (w_ext > LW'(MAX_WIDTH)) begin
      w_last = LW'(MAX_WIDTH - 1);
    end else begin
      w_last = w_ext - LW'(1);
    end
    if (image_height < HW'(mf3_pkg::WIN_SIZE)) begin
      h_last = HW'(mf3_pkg::WIN_SIZE - 1);
    end else if (image_height > HW'(mf3_pkg::MAX_HEIGHT)) begin
      h_last = HW'(mf3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = image_height - HW'(1);
    end
  end

  always_comb begin
    r         = pix_data.start_of_frame ? '0 : row_count;
    c         = pix_data.start_of_frame ? '0 : col_count;
    row_end   = LW'(c) >= w_last;
    frame_end = row_end && (HW'(r) >= h_last);
    if (row_end) begin
      col_count_next = '0;
      row_count_next = frame_end ? '0 : r + CW'(1);
    end else begin
      col_count_next = c + CW'(1);
      row_count_next = r;
    end
    entry.pixel   = pix_data.pixel;
    entry.col     = c;
    entry.out_row = r - CW'(mf3_pkg::WIN_HALF);
    entry.emit    = (r >= CW'(mf3_pkg::WIN_SIZE - 1)) && (c >= CW'(mf3_pkg::WIN_SIZE - 1));
    entry.last    = frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mf3_pkg::IMAGE_WIDTH_RST;
      image_height <= mf3_pkg::IMAGE_HEIGHT_RST;
      row_count    <= '0;
      col_count    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mf3_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          mf3_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        row_count <= row_count_next;
        col_count <= col_count_next;
      end
    end
  end

  a_row_end_wraps_col: assert property (@(posedge clk) disable iff (rst)
    push && row_end |=> col_count == '0)
    else $error("column counter did not wrap at end of row");

endmodule

// ===== sv/mf3_queue.sv =====
// short queue of classified pixels between the front end and the back end
module mf3_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mf3_pkg::entry_t entry,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output mf3_pkg::entry_t head
);

  localparam int AW = $clog2(mf3_pkg::Q_DEPTH);
  localparam int NW = $clog2(mf3_pkg::Q_DEPTH + 1);

  mf3_pkg::entry_t slots [mf3_pkg::Q_DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [NW-1:0]   count;

  assign full       = count == NW'(mf3_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(mf3_pkg::Q_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== sv/mf3_median.sv =====
// pipelined median of nine and the output register
module mf3_median (
  input  logic           clk,
  input  logic           rst,
  input  logic           win_valid,
  input  mf3_pkg::win_t  win,
  input  mf3_pkg::meta_t meta,
  input  logic           res_stall,
  output logic           res_valid,
  output mf3_pkg::res_t  res_data,
  output logic           adv
);

  localparam int N = mf3_pkg::WIN_SIZE;

  logic           vd;
  logic           ve;
  mf3_pkg::tri_t  rows [N];
  mf3_pkg::meta_t meta_d;
  mf3_pkg::meta_t meta_e;
  mf3_pkg::pix_t  lo_max;
  mf3_pkg::pix_t  mid_med;
  mf3_pkg::pix_t  hi_min;

  assign adv = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd        <= 1'b0;
      ve        <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      vd        <= win_valid;
      ve        <= vd;
      res_valid <= ve;
    end
  end

  // rows sorted, then max of lows, median of mids, min of highs
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < N; i++) begin
        rows[i] <= mf3_pkg::sort3(win[i*N], win[i*N+1], win[i*N+2]);
      end
      meta_d  <= meta;
      lo_max  <= mf3_pkg::max2(mf3_pkg::max2(rows[0].lo, rows[1].lo), rows[2].lo);
      mid_med <= mf3_pkg::med3(rows[0].mid, rows[1].mid, rows[2].mid);
      hi_min  <= mf3_pkg::min2(mf3_pkg::min2(rows[0].hi, rows[1].hi), rows[2].hi);
      meta_e  <= meta_d;
      res_data.median        <= mf3_pkg::med3(lo_max, mid_med, hi_min);
      res_data.out_row       <= meta_e.out_row;
      res_data.out_col       <= meta_e.out_col;
      res_data.last_of_frame <= meta_e.last_of_frame;
    end
  end

  a_pipe_moves: assert property (@(posedge clk) disable iff (rst)
    adv && ve |=> res_valid)
    else $error("median stage lost a transaction");

endmodule

// ===== sv/mf3_back.sv =====
// back end: line stores with bypass, 3x3 window and median pipeline
module mf3_back #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  mf3_pkg::entry_t head,
  input  logic            res_stall,
  output logic            pop,
  output logic            res_valid,
  output mf3_pkg::res_t   res_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int N  = mf3_pkg::WIN_SIZE;
  localparam int CW = mf3_pkg::CNT_W;

  mf3_pkg::pix_t line_lower [MAX_WIDTH];
  mf3_pkg::pix_t line_upper [MAX_WIDTH];

  logic            adv;
  logic            vb;
  mf3_pkg::entry_t eb;
  mf3_pkg::pix_t   rd_lo;
  mf3_pkg::pix_t   rd_up;
  logic            fwd;
  mf3_pkg::pix_t   fwd_lo;
  mf3_pkg::pix_t   fwd_up;
  mf3_pkg::pix_t   lo_eff;
  mf3_pkg::pix_t   up_eff;
  logic [AW-1:0]   addr_head;
  logic [AW-1:0]   addr_b;
  logic            vc;
  mf3_pkg::win_t   win;
  mf3_pkg::meta_t  meta_c;
  mf3_pkg::pix_t   col_new [N];

  assign pop       = adv && head_valid;
  assign addr_head = AW'(head.col);
  assign addr_b    = AW'(eb.col);
  assign lo_eff    = fwd ? fwd_lo : rd_lo;
  assign up_eff    = fwd ? fwd_up : rd_up;

  always_comb begin
    col_new[0] = up_eff;
    col_new[1] = lo_eff;
    col_new[2] = eb.pixel;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_lo <= line_lower[addr_head];
      rd_up <= line_upper[addr_head];
    end
    if (adv && vb) begin
      line_lower[addr_b] <= eb.pixel;
      line_upper[addr_b] <= lo_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (adv) begin
      vb <= head_valid;
      vc <= vb && eb.emit;
    end
  end

  // same address written one transaction earlier: take it from stage b
  always_ff @(posedge clk) begin
    if (pop) begin
      eb     <= head;
      fwd    <= vb && (addr_b == addr_head);
      fwd_lo <= eb.pixel;
      fwd_up <= lo_eff;
    end
    if (adv && vb) begin
      meta_c.out_row       <= eb.out_row;
      meta_c.out_col       <= eb.col - CW'(mf3_pkg::WIN_HALF);
      meta_c.last_of_frame <= eb.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (adv && vb) begin
      for (int i = 0; i < N; i++) begin
        for (int k = 0; k < N - 1; k++) begin
          win[i*N+k] <= win[i*N+k+1];
        end
        win[i*N+N-1] <= col_new[i];
      end
    end
  end

  mf3_median u_median (
    .clk       (clk),
    .rst       (rst),
    .win_valid (vc),
    .win       (win),
    .meta      (meta_c),
    .res_stall (res_stall),
    .res_valid (res_valid),
    .res_data  (res_data),
    .adv       (adv)
  );

  a_window_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(win))
    else $error("window changed while pipeline held");

endmodule

// ===== sv/median_filter_3x3_stream.sv =====
// top level of the streaming 3x3 median filter
// path: queue slot, line-store read, window register, row sort, column reduce, output register
// throughput: one pixel per cycle unless stalled, set by the line stores that take one read and
//   one write each cycle and the sort pipeline; a four-entry queue absorbs short output stalls
// reset: clears counters, window and pipeline valids, loads 512 into both
//   size registers; line stores are not cleared and need no initialisation after reset
module median_filter_3x3_stream #(
  parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  mf3_pkg::pixel_t               pix_data,
  output logic                          res_valid,
  input  logic                          res_stall,
  output mf3_pkg::res_t                 res_data
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            head_valid;
  mf3_pkg::entry_t entry;
  mf3_pkg::entry_t head;

  assign pix_stall = q_full;

  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_data  (pix_data),
    .q_full    (q_full),
    .push      (push),
    .entry     (entry)
  );

  mf3_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .entry      (entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  mf3_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .res_stall  (res_stall),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_data   (res_data)
  );

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the streaming 3x3 median filter
`timescale 1ns / 100ps

module tb;

  localparam int LIMIT    = 400000;
  localparam int SETTLE   = 8;
  localparam int N_RANDOM = 540;

  typedef enum logic [1:0] {OP_PIXEL, OP_CONFIG, OP_DRAIN} op_t;
  typedef enum logic [1:0] {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FULL} pace_t;
  typedef enum logic [1:0] {PIX_RANDOM, PIX_EXTREME, PIX_NARROW} pix_kind_t;

  typedef struct {
    op_t                           op;
    pace_t                         pace;
    mf3_pkg::pixel_t               px;
    logic [mf3_pkg::CFG_IDX_W-1:0] idx;
    logic [mf3_pkg::CFG_W-1:0]     val;
  } step_t;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mf3_pkg::CFG_W-1:0]     cfg_data  = '0;
  logic                          pix_valid = 1'b0;
  mf3_pkg::pixel_t               pix_data  = '0;
  logic                          res_stall = 1'b0;
  logic                          pix_stall;
  logic                          res_valid;
  mf3_pkg::res_t                 res_data;

  median_filter_3x3_stream u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  step_t         step_q[$];
  mf3_pkg::res_t median_q[$];

  int tx_pct_of[3] = '{16, 58, 0};
  int rx_pct_of[3] = '{58, 16, 0};
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_off     = 0;
  bit draining     = 1'b0;

  int cycles    = 0;
  int n_errors  = 0;
  int n_pixels  = 0;
  int n_results = 0;
  int n_frames  = 0;
  int n_cfg     = 0;

  // filter state as the block should hold it
  mf3_pkg::pix_t             upper_line [mf3_pkg::MAX_WIDTH_DEF];
  mf3_pkg::pix_t             lower_line [mf3_pkg::MAX_WIDTH_DEF];
  mf3_pkg::pix_t             win [mf3_pkg::WIN_AREA];
  int                        next_row   = 0;
  int                        next_col   = 0;
  logic [mf3_pkg::CFG_W-1:0] width_reg  = mf3_pkg::IMAGE_WIDTH_RST;
  logic [mf3_pkg::CFG_W-1:0] height_reg = mf3_pkg::IMAGE_HEIGHT_RST;

  // stimulus generation state
  pace_t gen_pace    = PACE_FULL;
  int    gen_w       = 512;
  int    gen_h       = 512;
  bit    gen_aligned = 1'b1;
  int    gen_items   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_size(input int v, input int hi);
    return (v < mf3_pkg::WIN_SIZE) ? mf3_pkg::WIN_SIZE : ((v > hi) ? hi : v);
  endfunction

  function automatic mf3_pkg::pix_t window_median();
    mf3_pkg::pix_t s [mf3_pkg::WIN_AREA];
    mf3_pkg::pix_t v;
    int            j;
    s = win;
    for (int i = 1; i < mf3_pkg::WIN_AREA; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[mf3_pkg::WIN_AREA/2];
  endfunction

  task automatic filter_pixel(input mf3_pkg::pixel_t p);
    int            w;
    int            h;
    int            r;
    int            c;
    bit            row_end;
    bit            frame_end;
    mf3_pkg::pix_t col [mf3_pkg::WIN_SIZE];
    mf3_pkg::res_t e;
    w = clamp_size(int'(width_reg), mf3_pkg::MAX_WIDTH_DEF);
    h = clamp_size(int'(height_reg), mf3_pkg::MAX_HEIGHT);
    if (p.start_of_frame) begin
      next_row = 0;
      next_col = 0;
    end
    r = next_row;
    c = next_col % mf3_pkg::MAX_WIDTH_DEF;
    col[0] = upper_line[c];
    col[1] = lower_line[c];
    col[2] = p.pixel;
    upper_line[c] = lower_line[c];
    lower_line[c] = p.pixel;
    for (int i = 0; i < mf3_pkg::WIN_SIZE; i++) begin
      win[i*mf3_pkg::WIN_SIZE]     = win[i*mf3_pkg::WIN_SIZE + 1];
      win[i*mf3_pkg::WIN_SIZE + 1] = win[i*mf3_pkg::WIN_SIZE + 2];
      win[i*mf3_pkg::WIN_SIZE + 2] = col[i];
    end
    row_end   = (c >= w - 1);
    frame_end = row_end && (r >= h - 1);
    if (row_end) begin
      next_col = 0;
      next_row = frame_end ? 0 : ((r + 1) & 'h7ff);
    end else begin
      next_col = (c + 1) & 'h7ff;
    end
    if (r >= mf3_pkg::WIN_SIZE - 1 && c >= mf3_pkg::WIN_SIZE - 1) begin
      e.median        = window_median();
      e.out_row       = mf3_pkg::CNT_W'(r - mf3_pkg::WIN_HALF);
      e.out_col       = mf3_pkg::CNT_W'(c - mf3_pkg::WIN_HALF);
      e.last_of_frame = frame_end;
      median_q.push_back(e);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    n_errors++;
  endtask

  task automatic add_pixel(input mf3_pkg::pix_t v, input logic sof);
    step_t st;
    st.op   = OP_PIXEL;
    st.pace = gen_pace;
    st.px.pixel = v;
    st.px.start_of_frame = sof;
    st.idx  = '0;
    st.val  = '0;
    step_q.push_back(st);
    gen_items++;
  endtask

  task automatic add_drain();
    step_t st;
    st.op   = OP_DRAIN;
    st.pace = gen_pace;
    st.px   = '0;
    st.idx  = '0;
    st.val  = '0;
    step_q.push_back(st);
  endtask

  task automatic add_config(input logic [mf3_pkg::CFG_IDX_W-1:0] idx, input int val);
    step_t st;
    add_drain();
    st.op   = OP_CONFIG;
    st.pace = gen_pace;
    st.px   = '0;
    st.idx  = idx;
    st.val  = mf3_pkg::CFG_W'(val);
    step_q.push_back(st);
    if (idx == mf3_pkg::REG_IMAGE_WIDTH)
      gen_w = clamp_size(val & 'hfff, mf3_pkg::MAX_WIDTH_DEF);
    else
      gen_h = clamp_size(val & 'hfff, mf3_pkg::MAX_HEIGHT);
  endtask

  function automatic mf3_pkg::pix_t pick_pixel(input pix_kind_t kind);
    case (kind)
      PIX_EXTREME: return $urandom_range(1) ? 8'hff : 8'h00;
      PIX_NARROW:  return mf3_pkg::pix_t'(100 + $urandom_range(3));
      default:     return mf3_pkg::pix_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    int pick;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(9, 3);
    if (r < 75) return $urandom_range(2, 0);
    if (r < 85) begin
      pick = $urandom_range(2);
      return (pick == 0) ? 2048 : ((pick == 1) ? 4095 : 2047);
    end
    return $urandom_range(4095, 10);
  endfunction

  task automatic add_frame(input int n, input logic sof, input pix_kind_t kind,
                           input int noise_pct);
    for (int i = 0; i < n; i++)
      add_pixel(pick_pixel(kind), (i == 0 && sof) || ($urandom_range(99) < noise_pct));
  endtask

  // driver: sequences pixels, register writes and drains from step_q
  always @(posedge clk) begin
    logic            nxt_valid;
    mf3_pkg::pixel_t nxt_data;
    logic            nxt_we;
    step_t           s;
    if (rst) begin
      pix_valid <= 1'b0;
      cfg_we    <= 1'b0;
      hold_off  = 0;
      draining  = 1'b0;
    end else begin
      nxt_valid = pix_valid;
      nxt_data  = pix_data;
      nxt_we    = 1'b0;
      if (pix_valid && !pix_stall) begin
        filter_pixel(pix_data);
        n_pixels++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (hold_off > 0) begin
          hold_off--;
        end else if (draining) begin
          if (median_q.size() == 0) begin
            draining = 1'b0;
            hold_off = SETTLE;
          end
        end else if (step_q.size() != 0) begin
          s = step_q[0];
          case (s.op)
            OP_PIXEL: begin
              tx_idle_pct = tx_pct_of[int'(s.pace)];
              rx_idle_pct = rx_pct_of[int'(s.pace)];
              if ($urandom_range(99) >= tx_idle_pct) begin
                nxt_valid = 1'b1;
                nxt_data  = s.px;
                void'(step_q.pop_front());
              end
            end
            OP_CONFIG: begin
              nxt_we = 1'b1;
              cfg_index <= s.idx;
              cfg_data  <= s.val;
              if (s.idx == mf3_pkg::REG_IMAGE_WIDTH)
                width_reg = s.val;
              else
                height_reg = s.val;
              n_cfg++;
              void'(step_q.pop_front());
            end
            OP_DRAIN: begin
              draining = 1'b1;
              void'(step_q.pop_front());
            end
            default: void'(step_q.pop_front());
          endcase
        end
      end
      pix_valid <= nxt_valid;
      pix_data  <= nxt_data;
      cfg_we    <= nxt_we;
    end
  end

  // monitor: random output stall and compare against the oldest expected median
  always @(posedge clk) begin
    mf3_pkg::res_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        n_results++;
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result median %0d row %0d col %0d",
                                    res_data.median, res_data.out_row, res_data.out_col));
        end else begin
          want = median_q.pop_front();
          if (res_data.median !== want.median)
            report_mismatch($sformatf("median got %0d want %0d at row %0d col %0d",
                                      res_data.median, want.median, want.out_row,
                                      want.out_col));
          if (res_data.out_row !== want.out_row)
            report_mismatch($sformatf("out_row got %0d want %0d",
                                      res_data.out_row, want.out_row));
          if (res_data.out_col !== want.out_col)
            report_mismatch($sformatf("out_col got %0d want %0d",
                                      res_data.out_col, want.out_col));
          if (res_data.last_of_frame !== want.last_of_frame)
            report_mismatch($sformatf("last_of_frame got %0b want %0b at row %0d col %0d",
                                      res_data.last_of_frame, want.last_of_frame,
                                      want.out_row, want.out_col));
          if (want.last_of_frame)
            n_frames++;
        end
      end
      res_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, median_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int        total;
    int        n;
    int        split;
    int        budget;
    int        r;
    bit        sof;
    pix_kind_t kind;

    for (int i = 0; i < mf3_pkg::WIN_AREA; i++)
      win[i] = '0;

    // 70-pixel rows written through both line stores, then the start of the tallest frame
    gen_pace = PACE_RX_SLOW;
    add_config(mf3_pkg::REG_IMAGE_WIDTH, 70);
    add_config(mf3_pkg::REG_IMAGE_HEIGHT, 0);
    add_frame(gen_w * gen_h, 1'b1, PIX_RANDOM, 0);
    add_config(mf3_pkg::REG_IMAGE_WIDTH, 0);
    add_config(mf3_pkg::REG_IMAGE_HEIGHT, 'hfff);
    add_frame(90, 1'b1, PIX_RANDOM, 0);

    // smallest frame: saturated windows, wrap without start_of_frame, duplicates
    gen_pace = PACE_RX_SLOW;
    add_config(mf3_pkg::REG_IMAGE_WIDTH, 3);
    add_config(mf3_pkg::REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 9; i++)
      add_pixel(8'hff, i == 0);
    for (int i = 0; i < 9; i++)
      add_pixel(8'h00, 1'b0);
    add_frame(9, 1'b1, PIX_NARROW, 0);

    // size registers changed in the middle of a frame, then a stray start_of_frame
    add_config(mf3_pkg::REG_IMAGE_WIDTH, 4);
    add_frame(6, 1'b1, PIX_EXTREME, 0);
    add_config(mf3_pkg::REG_IMAGE_WIDTH, 2);
    add_config(mf3_pkg::REG_IMAGE_HEIGHT, 1);
    add_frame(7, 1'b0, PIX_RANDOM, 0);
    add_pixel(8'h5a, 1'b1);
    add_frame(3, 1'b0, PIX_RANDOM, 0);
    gen_aligned = 1'b0;

    // random frames in three idling regimes
    for (int seg = 0; seg < 3; seg++) begin
      gen_pace = pace_t'(seg);
      budget = gen_items + N_RANDOM / 3;
      while (gen_items < budget) begin
        if ($urandom_range(99) < 30) begin
          r = $urandom_range(2);
          if (r != 1) add_config(mf3_pkg::REG_IMAGE_WIDTH, pick_size());
          if (r != 0) add_config(mf3_pkg::REG_IMAGE_HEIGHT, pick_size());
        end
        r = $urandom_range(99);
        kind = (r < 70) ? PIX_RANDOM : ((r < 85) ? PIX_NARROW : PIX_EXTREME);
        total = gen_w * gen_h;
        if (total <= 150 && $urandom_range(99) < 80) begin
          sof = !gen_aligned || $urandom_range(1);
          if ($urandom_range(99) < 12) begin
            split = $urandom_range(total - 1, 1);
            add_frame(split, sof, kind, 0);
            add_config($urandom_range(1) ? mf3_pkg::REG_IMAGE_HEIGHT
                                         : mf3_pkg::REG_IMAGE_WIDTH, pick_size());
            add_frame($urandom_range(20, 1), 1'b0, kind, 0);
            gen_aligned = 1'b0;
          end else begin
            add_frame(total, sof, kind, 0);
            gen_aligned = 1'b1;
          end
        end else begin
          n = $urandom_range((total < 60) ? total : 60, 1);
          add_frame(n, 1'b1, kind, 4);
          gen_aligned = 1'b0;
        end
      end
    end
    add_drain();

    wait (!rst);
    wait (step_q.size() == 0 && !draining && hold_off == 0 && !pix_valid);
    @(posedge clk);
    if (median_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", median_q.size()));
    $display("sent %0d pixels and %0d size register writes over three idling regimes",
             n_pixels, n_cfg);
    $display("checked %0d filtered pixels, %0d frame ends, %0d mismatches",
             n_results, n_frames, n_errors);
    if (n_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
